// File: src/mbp_pkg.sv
// ----------------------------------------------------------------------------
// mbp_pkg
// Shared types for the minimax bottleneck path block: channel payloads,
// controller states, and the command and status groups that run between
// the controller and the datapath.
// ----------------------------------------------------------------------------
package mbp_pkg;

    // Width of a node number as it travels on the input channel.
    localparam int NODE_BITS = 10;

    // Request codes carried in req_type.
    localparam logic REQ_ADD_EDGE = 1'b0;
    localparam logic REQ_SOLVE    = 1'b1;

    typedef struct packed {
        logic        req_type;
        logic [9:0]  edge_from;
        logic [9:0]  edge_to;
        logic [31:0] edge_weight;
    } in_item_t;

    typedef struct packed {
        logic [31:0] answer;
        logic        all_reached;
        logic        edges_dropped;
    } out_item_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_PASS_INIT,
        ST_EDGE_RD,
        ST_COST_RD,
        ST_RELAX,
        ST_SCAN_INIT,
        ST_SCAN_RD,
        ST_SCAN_CHK,
        ST_DONE
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic add_edge;
        logic clr_start;
        logic clr_step;
        logic pass_start;
        logic edge_rd;
        logic cost_rd;
        logic relax;
        logic scan_start;
        logic scan_rd;
        logic scan_chk;
        logic load_result;
    } cmd_t;

    // Status from the datapath back to the controller.
    typedef struct packed {
        logic clr_last;
        logic edge_empty;
        logic edge_last;
        logic changed;
        logic scan_empty;
        logic scan_last;
        logic out_free;
    } status_t;

endpackage

// File: src/mbp_ctrl.sv
// ----------------------------------------------------------------------------
// mbp_ctrl
// Sequencer for the solve: clears the cost store, sweeps the edge table
// until a full pass makes no change, scans the node range, and hands the
// result to the output register.
// ----------------------------------------------------------------------------
module mbp_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_accept,
    input  logic             in_solve,
    input  mbp_pkg::status_t st,
    output mbp_pkg::cmd_t    cmd,
    output logic             busy
);
    import mbp_pkg::*;

    state_t state_reg;
    state_t state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    if (in_solve)
                    begin
                        cmd.clr_start = 1'b1;
                        state_next    = ST_CLEAR;
                    end
                    else
                    begin
                        cmd.add_edge = 1'b1;
                    end
                end
            end
            ST_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (st.clr_last)
                begin
                    state_next = ST_PASS_INIT;
                end
            end
            ST_PASS_INIT:
            begin
                cmd.pass_start = 1'b1;
                state_next     = st.edge_empty ? ST_SCAN_INIT : ST_EDGE_RD;
            end
            ST_EDGE_RD:
            begin
                cmd.edge_rd = 1'b1;
                state_next  = ST_COST_RD;
            end
            ST_COST_RD:
            begin
                cmd.cost_rd = 1'b1;
                state_next  = ST_RELAX;
            end
            ST_RELAX:
            begin
                cmd.relax = 1'b1;
                if (st.edge_last)
                begin
                    state_next = st.changed ? ST_PASS_INIT : ST_SCAN_INIT;
                end
                else
                begin
                    state_next = ST_EDGE_RD;
                end
            end
            ST_SCAN_INIT:
            begin
                cmd.scan_start = 1'b1;
                state_next     = st.scan_empty ? ST_DONE : ST_SCAN_RD;
            end
            ST_SCAN_RD:
            begin
                cmd.scan_rd = 1'b1;
                state_next  = ST_SCAN_CHK;
            end
            ST_SCAN_CHK:
            begin
                cmd.scan_chk = 1'b1;
                if (st.scan_last)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = ST_SCAN_RD;
                end
            end
            ST_DONE:
            begin
                if (st.out_free)
                begin
                    cmd.load_result = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != ST_IDLE);

endmodule

// File: src/mbp_datapath.sv
// ----------------------------------------------------------------------------
// mbp_datapath
// Edge table, per-node cost store, relaxation unit, node scan and the
// output register, all driven by commands from the controller.
// ----------------------------------------------------------------------------
module mbp_datapath #(
    parameter int MAX_NODES   = 1024,
    parameter int MAX_EDGES   = 4096,
    parameter int WEIGHT_BITS = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  mbp_pkg::cmd_t      cmd,
    output mbp_pkg::status_t   st,
    input  mbp_pkg::in_item_t  in_item,
    input  logic               cfg_we,
    input  logic [9:0]         cfg_wdata,
    output logic               out_valid,
    input  logic               out_stall,
    output mbp_pkg::out_item_t out_item
);
    import mbp_pkg::*;

    localparam int W   = WEIGHT_BITS;
    localparam int CW  = WEIGHT_BITS + 1;
    localparam int NAW = $clog2(MAX_NODES);
    localparam int EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int ECW = $clog2(MAX_EDGES + 1);
    localparam int EW  = 2 * NODE_BITS + WEIGHT_BITS;

    localparam logic [CW-1:0]  COST_INF  = {1'b1, {W{1'b0}}};
    localparam logic [ECW-1:0] EDGE_FULL = ECW'(MAX_EDGES);
    localparam logic [NAW-1:0] NODE_LAST = NAW'(MAX_NODES - 1);
    localparam logic [NAW-1:0] NODE_ONE  = NAW'(1);

    // Storage.
    logic [EW-1:0] edge_mem [MAX_EDGES];
    logic [CW-1:0] cost_mem [MAX_NODES];

    // Registers.
    logic [9:0]     node_count_reg;
    logic [ECW-1:0] edge_count_reg;
    logic           overflow_reg;
    logic [NAW-1:0] clr_idx_reg;
    logic [ECW-1:0] eidx_reg;
    logic           changed_reg;
    logic [NAW-1:0] sidx_reg;
    logic [EW-1:0]  edge_q_reg;
    logic [CW-1:0]  ca_reg;
    logic [CW-1:0]  cb_reg;
    logic [W-1:0]   ans_reg;
    logic           reached_reg;
    logic           out_valid_reg;
    out_item_t      out_item_reg;

    // Incoming edge, weight trimmed to the stored width.
    logic [63:0]    w_in_ext;
    logic [W-1:0]   w_in;
    logic           table_full;

    assign w_in_ext   = 64'(in_item.edge_weight);
    assign w_in       = w_in_ext[W-1:0];
    assign table_full = (edge_count_reg == EDGE_FULL);

    // Fields of the edge under relaxation.
    logic [NODE_BITS-1:0] e_from;
    logic [NODE_BITS-1:0] e_to;
    logic [W-1:0]         e_w;
    logic [31:0]          a_ext;
    logic [31:0]          b_ext;
    logic [NAW-1:0]       a_idx;
    logic [NAW-1:0]       b_idx;
    logic                 e_ok;

    assign e_from = edge_q_reg[EW-1 -: NODE_BITS];
    assign e_to   = edge_q_reg[W+NODE_BITS-1 -: NODE_BITS];
    assign e_w    = edge_q_reg[W-1:0];
    assign a_ext  = 32'(e_from);
    assign b_ext  = 32'(e_to);
    assign a_idx  = a_ext[NAW-1:0];
    assign b_idx  = b_ext[NAW-1:0];
    assign e_ok   = (a_ext < 32'(MAX_NODES)) && (b_ext < 32'(MAX_NODES));

    // Relaxation in both directions; at most one endpoint can improve.
    logic [CW-1:0] w_cost;
    logic [CW-1:0] via_a;
    logic [CW-1:0] via_b;
    logic          hit_b;
    logic          hit_a;

    assign w_cost = CW'(e_w);
    assign via_a  = (ca_reg > w_cost) ? ca_reg : w_cost;
    assign via_b  = (cb_reg > w_cost) ? cb_reg : w_cost;
    assign hit_b  = e_ok && !ca_reg[W] && (via_a < cb_reg);
    assign hit_a  = e_ok && !hit_b && !cb_reg[W] && (via_b < ca_reg);

    // Node range for the scan, capped to the cost store.
    logic [31:0]    n_ext;
    logic [31:0]    n_lim32;
    logic [NAW-1:0] n_lim;

    assign n_ext   = 32'(node_count_reg);
    assign n_lim32 = (n_ext >= 32'(MAX_NODES)) ? 32'(MAX_NODES - 1) : n_ext;
    assign n_lim   = n_lim32[NAW-1:0];

    // Status back to the controller.
    always_comb
    begin
        st            = '0;
        st.clr_last   = (clr_idx_reg == NODE_LAST);
        st.edge_empty = (edge_count_reg == '0);
        st.edge_last  = (ECW'(eidx_reg + 1'b1) == edge_count_reg);
        st.changed    = changed_reg || hit_a || hit_b;
        st.scan_empty = (n_lim32 == 32'd0);
        st.scan_last  = (sidx_reg == n_lim);
        st.out_free   = !out_valid_reg || !out_stall;
    end

    // Configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_count_reg <= 10'd1;
        end
        else if (cfg_we)
        begin
            node_count_reg <= cfg_wdata;
        end
    end

    // Edge table fill count and overflow flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            edge_count_reg <= '0;
            overflow_reg   <= 1'b0;
        end
        else if (cmd.load_result)
        begin
            edge_count_reg <= '0;
            overflow_reg   <= 1'b0;
        end
        else if (cmd.add_edge)
        begin
            if (table_full)
            begin
                overflow_reg <= 1'b1;
            end
            else
            begin
                edge_count_reg <= ECW'(edge_count_reg + 1'b1);
            end
        end
    end

    // Edge table write and read.
    always_ff @(posedge clk)
    begin
        if (cmd.add_edge && !table_full)
        begin
            edge_mem[edge_count_reg[EAW-1:0]] <= {in_item.edge_from, in_item.edge_to, w_in};
        end
        if (cmd.edge_rd)
        begin
            edge_q_reg <= edge_mem[eidx_reg[EAW-1:0]];
        end
    end

    // Cost store: one write port shared by the clear sweep and relaxation,
    // two registered read ports for the edge endpoints or the scan.
    always_ff @(posedge clk)
    begin
        if (cmd.clr_step)
        begin
            cost_mem[clr_idx_reg] <= (clr_idx_reg == NODE_ONE) ? '0 : COST_INF;
        end
        else if (cmd.relax && hit_b)
        begin
            cost_mem[b_idx] <= via_a;
        end
        else if (cmd.relax && hit_a)
        begin
            cost_mem[a_idx] <= via_b;
        end

        if (cmd.cost_rd)
        begin
            ca_reg <= cost_mem[a_idx];
            cb_reg <= cost_mem[b_idx];
        end
        else if (cmd.scan_rd)
        begin
            ca_reg <= cost_mem[sidx_reg];
        end
    end

    // Sweep counters and the pass change flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_idx_reg <= '0;
            eidx_reg    <= '0;
            changed_reg <= 1'b0;
            sidx_reg    <= '0;
        end
        else
        begin
            if (cmd.clr_start)
            begin
                clr_idx_reg <= '0;
            end
            else if (cmd.clr_step)
            begin
                clr_idx_reg <= NAW'(clr_idx_reg + 1'b1);
            end

            if (cmd.pass_start)
            begin
                eidx_reg    <= '0;
                changed_reg <= 1'b0;
            end
            else if (cmd.relax)
            begin
                eidx_reg    <= ECW'(eidx_reg + 1'b1);
                changed_reg <= changed_reg || hit_a || hit_b;
            end

            if (cmd.scan_start)
            begin
                sidx_reg <= NODE_ONE;
            end
            else if (cmd.scan_chk)
            begin
                sidx_reg <= NAW'(sidx_reg + 1'b1);
            end
        end
    end

    // Running maximum and reach flag over the node range.
    always_ff @(posedge clk)
    begin
        if (cmd.scan_start)
        begin
            ans_reg     <= '0;
            reached_reg <= 1'b1;
        end
        else if (cmd.scan_chk)
        begin
            if (ca_reg[W])
            begin
                reached_reg <= 1'b0;
            end
            else if (ca_reg[W-1:0] > ans_reg)
            begin
                ans_reg <= ca_reg[W-1:0];
            end
        end
    end

    // Result formatting: an unreached node saturates the answer.
    logic [W-1:0] final_ans;
    logic [63:0]  final_ext;

    assign final_ans = reached_reg ? ans_reg : {W{1'b1}};
    assign final_ext = 64'(final_ans);

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_result)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_result)
        begin
            out_item_reg.answer        <= final_ext[31:0];
            out_item_reg.all_reached   <= reached_reg;
            out_item_reg.edges_dropped <= overflow_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule

// File: src/minimax_bottleneck_path_max_top.sv
// ----------------------------------------------------------------------------
// minimax_bottleneck_path_max_top
// Single-source minimax path cost engine: loads undirected weighted edges
// and, on a solve request, reports the largest bottleneck cost from node 1.
//
//   Channel   Signals                         Moves
//   in        in_valid / in_stall / in_item   add-edge or solve request
//   out       out_valid / out_stall / out_item one result per solve
//   cfg       cfg_we / cfg_wdata              node_count register write
//
// Add-edge transfers may stream in back to back.
// A solve clears the cost store, then sweeps the edge table in passes
// (per edge: table read, endpoint cost read, relaxation), repeated until
// a pass changes nothing, then scans the node range and loads the
// output register.
// Reset leaves the edge table empty and node_count at 1. The input stalls
// for the whole solve and while the finished result cannot be loaded.
// ----------------------------------------------------------------------------
module minimax_bottleneck_path_max_top #(
    parameter int MAX_NODES   = 1024,
    parameter int MAX_EDGES   = 4096,
    parameter int WEIGHT_BITS = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  mbp_pkg::in_item_t  in_item,
    output logic               out_valid,
    input  logic               out_stall,
    output mbp_pkg::out_item_t out_item,
    input  logic               cfg_we,
    input  logic [9:0]         cfg_wdata
);
    import mbp_pkg::*;

    cmd_t    cmd;
    status_t st;
    logic    busy;
    logic    in_accept;

    // An input transfer completes whenever the controller is idle.
    assign in_stall  = busy;
    assign in_accept = in_valid && !busy;

    mbp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_accept (in_accept),
        .in_solve  (in_item.req_type == REQ_SOLVE),
        .st        (st),
        .cmd       (cmd),
        .busy      (busy)
    );

    mbp_datapath #(
        .MAX_NODES   (MAX_NODES),
        .MAX_EDGES   (MAX_EDGES),
        .WEIGHT_BITS (WEIGHT_BITS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .st        (st),
        .in_item   (in_item),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item)
    );

    // A solve transfer starts a busy period.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && (in_item.req_type == REQ_SOLVE)) |=> in_stall)
        else $error("solve transfer did not start the solve");

    // An add-edge transfer leaves the input ready for the next one.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && (in_item.req_type == REQ_ADD_EDGE)) |=> !in_stall)
        else $error("add-edge transfer stalled the input");

    // A new result appears only as the solve finishes.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $fell(in_stall))
        else $error("result loaded outside the end of a solve");

endmodule

// File: test/minimax_bottleneck_path_max_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// minimax_bottleneck_path_max_top_tb
// Self-checking bench for the minimax path cost engine. It loads undirected
// edge sets, requests solves, and compares every result with a bottleneck
// cost computed here by relaxation over the same edge set. Both channels
// idle at random, the receiver holds off for a long stretch once, and the
// node_count register is moved through its range between solves.
// ----------------------------------------------------------------------------
module minimax_bottleneck_path_max_top_tb;
    import mbp_pkg::*;

    localparam int          NODE_SLOTS    = 1024;
    localparam int          EDGE_SLOTS    = 4096;
    localparam int          HALF_PERIOD   = 6;
    localparam int          RESET_CYCLES  = 10;
    localparam int          SETTLE_CYCLES = 8;
    localparam int          CYCLE_LIMIT   = 40_000_000;
    localparam int          RANDOM_ITEMS  = 1000;
    localparam int          MAX_PRINTED   = 100;
    localparam logic [32:0] UNREACHED     = 33'h1_0000_0000;

    typedef struct packed {
        logic [9:0]  src;
        logic [9:0]  dst;
        logic [31:0] weight;
    } edge_rec_t;

    // Keeps the loaded edge set, works out each solve, and checks results.
    class bottleneck_scoreboard;
        edge_rec_t   edges[$];
        logic        dropped;
        logic [9:0]  node_count;
        logic [32:0] best[NODE_SLOTS];
        out_item_t   expected_q[$];
        int          mismatches;
        int          solves_checked;

        function new();
            dropped        = 1'b0;
            node_count     = 10'd1;
            mismatches     = 0;
            solves_checked = 0;
        endfunction

        function void set_node_count(input logic [9:0] value);
            node_count = value;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        // Lowers the cost of b if reaching it through a is cheaper.
        function bit relax_toward(input logic [9:0] a, input logic [9:0] b,
                                  input logic [31:0] w);
            logic [32:0] via;
            if (best[a][32])
                return 1'b0;
            via = (best[a] > {1'b0, w}) ? best[a] : {1'b0, w};
            if (via < best[b])
            begin
                best[b] = via;
                return 1'b1;
            end
            return 1'b0;
        endfunction

        // Bottleneck cost from node 1, relaxed both ways until it settles.
        function out_item_t solve_graph();
            out_item_t   res;
            bit          progress;
            logic [32:0] worst;
            for (int i = 0; i < NODE_SLOTS; i++)
                best[i] = UNREACHED;
            best[1]  = '0;
            progress = 1'b1;
            while (progress)
            begin
                progress = 1'b0;
                foreach (edges[k])
                begin
                    if (relax_toward(edges[k].src, edges[k].dst, edges[k].weight))
                        progress = 1'b1;
                    if (relax_toward(edges[k].dst, edges[k].src, edges[k].weight))
                        progress = 1'b1;
                end
            end
            res.all_reached = 1'b1;
            worst = '0;
            for (int i = 1; i <= int'(node_count); i++)
            begin
                if (best[i][32])
                    res.all_reached = 1'b0;
                else if (best[i] > worst)
                    worst = best[i];
            end
            res.answer        = res.all_reached ? worst[31:0] : '1;
            res.edges_dropped = dropped;
            return res;
        endfunction

        // Accepted input transfer: store an edge, or solve and clear.
        function void note_input(input in_item_t item);
            edge_rec_t rec;
            if (item.req_type == REQ_SOLVE)
            begin
                expected_q.insert(expected_q.size(), solve_graph());
                edges.delete();
                dropped = 1'b0;
            end
            else if (edges.size() >= EDGE_SLOTS)
                dropped = 1'b1;
            else
            begin
                rec.src    = item.edge_from;
                rec.dst    = item.edge_to;
                rec.weight = item.edge_weight;
                edges.insert(edges.size(), rec);
            end
        endfunction

        task report_mismatch(input string what);
            if (mismatches < MAX_PRINTED)
                $display("ERROR at %0t: %s", $time, what);
            mismatches++;
        endtask

        // Accepted output transfer: compare with the oldest solve.
        task check_result(input out_item_t got);
            out_item_t want;
            if (expected_q.size() == 0)
            begin
                report_mismatch($sformatf("result with no solve waiting: answer %h",
                                          got.answer));
                return;
            end
            want = expected_q.pop_front();
            solves_checked++;
            if (got.answer !== want.answer)
                report_mismatch($sformatf("solve %0d: answer %h, expected %h",
                                          solves_checked, got.answer, want.answer));
            if (got.all_reached !== want.all_reached)
                report_mismatch($sformatf("solve %0d: all_reached %b, expected %b",
                                          solves_checked, got.all_reached,
                                          want.all_reached));
            if (got.edges_dropped !== want.edges_dropped)
                report_mismatch($sformatf("solve %0d: edges_dropped %b, expected %b",
                                          solves_checked, got.edges_dropped,
                                          want.edges_dropped));
        endtask
    endclass

    logic      clk = 1'b0;
    logic      rst_n;
    logic      in_valid;
    logic      in_stall;
    in_item_t  in_item;
    logic      out_valid;
    logic      out_stall;
    out_item_t out_item;
    logic      cfg_we;
    logic [9:0] cfg_wdata;

    int idle_pct      = 36;
    int hold_left     = 0;
    int items_offered = 0;
    int cycle_count   = 0;

    bottleneck_scoreboard sb;

    minimax_bottleneck_path_max_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    // Clock generation.
    always
    begin
        #HALF_PERIOD clk = 1'b1;
        #HALF_PERIOD clk = 1'b0;
    end

    // Run limit.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("minimax_bottleneck_path_max_top: mismatch");
            $finish;
        end
    end

    // Watch both channels for completed transfers.
    always @(posedge clk)
    begin
        if (rst_n === 1'b1)
        begin
            if (in_valid && !in_stall)
                sb.note_input(in_item);
            if (out_valid && !out_stall)
                sb.check_result(out_item);
        end
    end

    // Result receiver: random stalls, or a long hold-off when one is requested.
    initial
    begin
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else
                out_stall <= ($urandom_range(0, 99) < idle_pct);
        end
    end

    // Offers one input transfer, after a random idle gap, and waits for it.
    task automatic send_item(input in_item_t item);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= item;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        items_offered++;
    endtask

    task automatic add_edge(input logic [9:0] a, input logic [9:0] b,
                            input logic [31:0] w);
        in_item_t item;
        item.req_type    = REQ_ADD_EDGE;
        item.edge_from   = a;
        item.edge_to     = b;
        item.edge_weight = w;
        send_item(item);
    endtask

    // The edge fields of a solve are ignored, so they carry noise.
    task automatic request_solve();
        in_item_t item;
        item.req_type    = REQ_SOLVE;
        item.edge_from   = 10'($urandom_range(0, 1023));
        item.edge_to     = 10'($urandom_range(0, 1023));
        item.edge_weight = $urandom;
        send_item(item);
    endtask

    // Stops offering input until every pending solve has reported.
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_node_count(input logic [9:0] value);
        settle();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.set_node_count(value);
    endtask

    // Weights lean toward ties and the two extremes.
    function automatic logic [31:0] pick_weight();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            2, 3:    return 32'($urandom_range(0, 15));
            default: return $urandom;
        endcase
    endfunction

    // Mostly nodes near the counted range, sometimes anywhere.
    function automatic logic [9:0] pick_node(input int hi);
        if ($urandom_range(0, 99) < 85)
            return 10'($urandom_range(0, hi));
        return 10'($urandom_range(0, 1023));
    endfunction

    // Loads one random graph: often a shuffled spanning tree plus extra edges.
    task automatic random_graph();
        int          n;
        int          hi;
        int          extra;
        int          j;
        int          tmp;
        int          order[$];
        logic [9:0]  a;
        logic [9:0]  b;
        n     = int'(sb.node_count);
        hi    = (n + 1 > 1023) ? 1023 : n + 1;
        extra = $urandom_range(0, 16);
        if (n >= 2 && n <= 16 && $urandom_range(0, 99) < 60)
        begin
            for (int v = 2; v <= n; v++)
                order.insert(order.size(), v);
            for (int k = order.size() - 1; k > 0; k--)
            begin
                j        = $urandom_range(0, k);
                tmp      = order[k];
                order[k] = order[j];
                order[j] = tmp;
            end
            foreach (order[k])
            begin
                a = 10'(order[k]);
                b = 10'($urandom_range(1, order[k] - 1));
                if ($urandom_range(0, 1) == 1)
                    add_edge(a, b, pick_weight());
                else
                    add_edge(b, a, pick_weight());
            end
            extra = $urandom_range(0, 6);
        end
        for (int k = 0; k < extra; k++)
            add_edge(pick_node(hi), pick_node(hi), pick_weight());
    endtask

    // Main stimulus.
    initial
    begin
        logic [9:0] nc;
        int         random_base;
        int         offered;
        int         pick;

        sb = new();
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        in_item   <= '0;
        cfg_we    <= 1'b0;
        cfg_wdata <= '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Out of reset only node 1 is counted, and it costs nothing.
        request_solve();

        // Empty node range.
        write_node_count(10'd0);
        add_edge(10'd1, 10'd2, 32'd77);
        request_solve();

        // Heaviest edge, lightest edge, then no edge at all.
        write_node_count(10'd2);
        add_edge(10'd1, 10'd2, '1);
        request_solve();
        add_edge(10'd2, 10'd1, '0);
        request_solve();
        request_solve();

        // Detours through node 0 and through nodes above the counted range.
        write_node_count(10'd3);
        add_edge(10'd1, 10'd0, 32'd5);
        add_edge(10'd0, 10'd3, 32'd7);
        add_edge(10'd3, 10'd2, 32'd2);
        add_edge(10'd1, 10'd2, 32'd9);
        request_solve();
        add_edge(10'd1, 10'd900, 32'd3);
        add_edge(10'd900, 10'd2, 32'd4);
        add_edge(10'd2, 10'd3, 32'd1);
        add_edge(10'd1023, 10'd3, 32'hAAAA_AAAA);
        add_edge(10'h155, 10'h2AA, 32'h5555_5555);
        request_solve();

        // Nodes reached only at the all-ones cost still count as reached.
        add_edge(10'd1, 10'd2, '1);
        add_edge(10'd3, 10'd2, '1);
        request_solve();

        // A chain through every node up to the top of the register range.
        write_node_count(10'd1023);
        for (int v = 1; v < 1023; v++)
            add_edge(10'(v), 10'(v + 1), $urandom);
        request_solve();
        add_edge(10'd1, 10'd1023, 32'd3);
        request_solve();

        // Receiver holds off while several graphs queue up behind it.
        write_node_count(10'd6);
        hold_left = 5000;
        for (int g = 0; g < 3; g++)
        begin
            random_graph();
            request_solve();
        end
        // Sender waits for every result before going on.
        settle();

        // Random graphs, with a stretch where neither side idles.
        random_base = items_offered;
        while (items_offered - random_base < RANDOM_ITEMS)
        begin
            offered  = items_offered - random_base;
            idle_pct = (offered >= 300 && offered < 600) ? 0 : 36;
            pick     = $urandom_range(0, 99);
            if (pick < 20)
            begin
                case ($urandom_range(0, 19))
                    0:       nc = 10'd1023;
                    1:       nc = 10'($urandom_range(0, 1023));
                    default: nc = 10'($urandom_range(0, 12));
                endcase
                write_node_count(nc);
            end
            else if (pick < 24)
                settle();
            random_graph();
            if ($urandom_range(0, 99) < 90)
                request_solve();
            if ($urandom_range(0, 99) < 5)
                request_solve();
        end
        idle_pct = 36;

        // Drain, then leave time for any stray result to show up.
        settle();
        repeat (64) @(posedge clk);
        if (sb.mismatches == 0)
            $display("minimax_bottleneck_path_max_top: match");
        else
            $display("minimax_bottleneck_path_max_top: mismatch");
        $finish;
    end

endmodule
